### rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Types and constants shared by the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam int OP_W  = 3;
    localparam int VAL_W = 32;
    localparam int POS_W = 5;
    localparam int LEN_W = 5;
    localparam int ST_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST = 3'd0,
        OP_INS_LAST  = 3'd1,
        OP_DEL_FIRST = 3'd2,
        OP_DEL_LAST  = 3'd3,
        OP_INS_AT    = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DUMP      = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_DUMP,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic    valid;
        logic    from_mem;
        status_t status;
        logic    last;
    } ple_res_t;

endpackage

### rtl/core/ple_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/ple_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer for the list: decodes each item, walks the entry pointer to
// shift entries one per cycle through the RAM, and steps the dump.
// ----------------------------------------------------------------------------
module ple_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ple_pkg::OP_W-1:0]           opcode,
    input  logic signed [ple_pkg::VAL_W-1:0]   value,
    input  logic [ple_pkg::POS_W-1:0]          position,
    output logic                               ram_we,
    output logic [$clog2(CAPACITY)-1:0]        ram_waddr,
    output logic [ple_pkg::VAL_W-1:0]          ram_wdata,
    output logic                               ram_re,
    output logic [$clog2(CAPACITY)-1:0]        ram_raddr,
    input  logic [ple_pkg::VAL_W-1:0]          ram_rdata,
    output ple_pkg::ple_res_t                  res,
    output logic [$clog2(CAPACITY+1)-1:0]      count
);

    import ple_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    state_t              state_reg,  state_next;
    logic [CW-1:0]       count_reg,  count_next;
    logic [CW-1:0]       ptr_reg,    ptr_next;
    logic [CW-1:0]       idx_reg,    idx_next;
    logic                pend_reg,   pend_next;
    logic [AW-1:0]       wa_reg,     wa_next;
    status_t             status_reg, status_next;
    op_t                 op_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [POS_W-1:0]    pos_reg;

    logic [XW-1:0]       pos_x;
    logic [XW-1:0]       cnt_x;
    logic                full;
    logic                empty;
    logic                accept;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign count  = count_reg;
    assign pos_x  = XW'(pos_reg);
    assign cnt_x  = XW'(count_reg);
    assign full   = (count_reg == CW'(CAPACITY));
    assign empty  = (count_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        idx_reg    <= idx_next;
        wa_reg     <= wa_next;
        status_reg <= status_next;
        if (accept)
        begin
            op_reg  <= op_t'(opcode);
            val_reg <= value;
            pos_reg <= position;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        wa_next     = wa_reg;
        status_next = status_reg;
        ram_we      = 1'b0;
        ram_waddr   = wa_reg;
        ram_wdata   = ram_rdata;
        ram_re      = 1'b0;
        ram_raddr   = ptr_reg[AW-1:0];
        res         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                pend_next = 1'b0;
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                status_next = ST_OK;
                unique case (op_reg) inside
                    OP_INS_FIRST, OP_INS_LAST, OP_INS_AT:
                    begin
                        ptr_next = count_reg;
                        if (op_reg == OP_INS_FIRST)
                        begin
                            idx_next = '0;
                        end
                        else if (op_reg == OP_INS_LAST)
                        begin
                            idx_next = count_reg;
                        end
                        else
                        begin
                            idx_next = CW'(pos_x - XW'(1));
                        end
                        if (full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_RESULT;
                        end
                        else if (op_reg == OP_INS_AT &&
                                 (pos_reg == '0 || pos_x > cnt_x + XW'(1)))
                        begin
                            status_next = ST_BADPOS;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_SHIFT_UP;
                        end
                    end
                    OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT:
                    begin
                        if (op_reg == OP_DEL_FIRST)
                        begin
                            ptr_next = '0;
                        end
                        else if (op_reg == OP_DEL_LAST)
                        begin
                            ptr_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            ptr_next = CW'(pos_x - XW'(1));
                        end
                        if (empty)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_RESULT;
                        end
                        else if (op_reg == OP_DEL_AT &&
                                 (pos_reg == '0 || pos_x > cnt_x))
                        begin
                            status_next = ST_BADPOS;
                            state_next  = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_SHIFT_DOWN;
                        end
                    end
                    OP_DUMP:
                    begin
                        ptr_next   = '0;
                        state_next = empty ? S_RESULT : S_DUMP;
                    end
                    default:
                    begin
                        state_next = S_RESULT;
                    end
                endcase
            end

            S_SHIFT_UP:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    pend_next = 1'b0;
                end
                if (ptr_reg > idx_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(ptr_reg - CW'(1));
                    pend_next = 1'b1;
                    wa_next   = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg - CW'(1);
                end
                else if (!pend_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = idx_reg[AW-1:0];
                    ram_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_RESULT;
                end
            end

            S_SHIFT_DOWN:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    pend_next = 1'b0;
                end
                if ((ptr_reg + CW'(1)) < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(ptr_reg + CW'(1));
                    pend_next = 1'b1;
                    wa_next   = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + CW'(1);
                end
                else if (!pend_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESULT;
                end
            end

            S_DUMP:
            begin
                if (pend_reg)
                begin
                    res.valid    = 1'b1;
                    res.from_mem = 1'b1;
                    res.status   = ST_OK;
                    res.last     = ((CW'(wa_reg) + CW'(1)) == count_reg);
                    pend_next    = 1'b0;
                    if (res.last)
                    begin
                        state_next = S_IDLE;
                    end
                end
                if (ptr_reg < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_reg[AW-1:0];
                    pend_next = 1'b1;
                    wa_next   = ptr_reg[AW-1:0];
                    ptr_next  = ptr_reg + CW'(1);
                end
            end

            S_RESULT:
            begin
                res.valid  = 1'b1;
                res.status = status_reg;
                res.last   = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DUMP || state_reg == S_RESULT) |-> !ram_we)
        else $error("RAM write outside a shift");

    a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        ($past(state_reg) == S_SHIFT_UP || $past(state_reg) == S_SHIFT_DOWN))
        else $error("count changed outside a shift");

    a_dump_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP && res.valid && res.last) |-> (ptr_reg == count_reg))
        else $error("dump ended before all entries were read");

    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> busy)
        else $error("result issued while idle");
`endif

endmodule

### rtl/core/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values with positional insert and delete.
// ----------------------------------------------------------------------------
// Usage:
//   An item (opcode, value, position) is taken when start is high and busy
//   is low. busy stays high until the item's last result has been issued.
//   Each result is shown for one cycle on element, status, length and last,
//   qualified by result_valid; the receiver takes it in that cycle and
//   cannot stall. Every item gives one result, except a dump of a non-empty
//   list, which gives one result per entry in order, last on the final one.
//   Entries live in a RAM with registered read; one pointer steps through
//   it moving one entry per cycle, and a dump issues its results on
//   consecutive cycles. Results are registered and appear in the cycle
//   after the sequencer emits them. Reset empties the list; RAM contents
//   are not cleared and need no pass.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ple_pkg::OP_W-1:0]           opcode,
    input  logic signed [ple_pkg::VAL_W-1:0]   value,
    input  logic [ple_pkg::POS_W-1:0]          position,
    output logic                               result_valid,
    output logic signed [ple_pkg::VAL_W-1:0]   element,
    output logic [ple_pkg::ST_W-1:0]           status,
    output logic [ple_pkg::LEN_W-1:0]          length,
    output logic                               last
);

    import ple_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [VAL_W-1:0]  ram_rdata;
    ple_res_t          res;
    logic [CW-1:0]     count;

    logic              valid_reg;
    logic [VAL_W-1:0]  element_reg;
    logic [ST_W-1:0]   status_reg;
    logic [LEN_W-1:0]  length_reg;
    logic              last_reg;

    ple_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .value     (value),
        .position  (position),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res       (res),
        .count     (count)
    );

    ple_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            element_reg <= res.from_mem ? ram_rdata : '0;
            status_reg  <= res.status;
            length_reg  <= LEN_W'(count);
            last_reg    <= res.last;
        end
    end

    assign result_valid = valid_reg;
    assign element      = element_reg;
    assign status       = status_reg;
    assign length       = length_reg;
    assign last         = last_reg;

endmodule

### verif/positional_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Self-checking bench for the positional list engine. A shadow copy of the
// list predicts every result as items are taken; the result strobe is
// compared field by field against the oldest prediction. A directed pass
// covers empty, full, bad position and dump cases, then random sequences
// fill and drain the list with random sender gaps.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;

    import ple_pkg::*;

    localparam int CAP          = 16;
    localparam int RANDOM_ITEMS = 330;

    localparam logic [OP_W-1:0]         OP_UNUSED = 3'd7;
    localparam logic signed [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;

    typedef struct {
        logic signed [VAL_W-1:0] element;
        logic [ST_W-1:0]         status;
        logic [LEN_W-1:0]        length;
        logic                    last;
    } list_result_t;

    // Shadow list and the results it still owes.
    class list_shadow;
        logic signed [VAL_W-1:0] slots [CAP];
        int unsigned             used;
        list_result_t            awaited [$];
        int unsigned             errors;

        function new();
            used   = 0;
            errors = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        function void owe(input logic signed [VAL_W-1:0] el, input logic [ST_W-1:0] st,
                          input logic lst);
            list_result_t r;
            r.element = el;
            r.status  = st;
            r.length  = used[LEN_W-1:0];
            r.last    = lst;
            awaited.push_back(r);
        endfunction

        function void put(input int unsigned idx, input logic signed [VAL_W-1:0] v);
            int unsigned i;
            for (i = used; i > idx; i--)
                slots[i] = slots[i-1];
            slots[idx] = v;
            used++;
        endfunction

        function void take(input int unsigned idx);
            int unsigned i;
            for (i = idx; i + 1 < used; i++)
                slots[i] = slots[i+1];
            used--;
        endfunction

        function void note_item(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                                input logic [POS_W-1:0] pos);
            logic [ST_W-1:0] st;
            int unsigned     i;
            st = ST_OK;
            case (op)
                OP_INS_FIRST, OP_INS_LAST, OP_INS_AT:
                begin
                    if (used >= CAP)
                        st = ST_FULL;
                    else if (op == OP_INS_FIRST)
                        put(0, val);
                    else if (op == OP_INS_LAST)
                        put(used, val);
                    else if (pos < 1 || pos > used + 1)
                        st = ST_BADPOS;
                    else
                        put(pos - 1, val);
                end
                OP_DEL_FIRST, OP_DEL_LAST, OP_DEL_AT:
                begin
                    if (used == 0)
                        st = ST_EMPTY;
                    else if (op == OP_DEL_FIRST)
                        take(0);
                    else if (op == OP_DEL_LAST)
                        take(used - 1);
                    else if (pos < 1 || pos > used)
                        st = ST_BADPOS;
                    else
                        take(pos - 1);
                end
                OP_DUMP:
                begin
                    if (used != 0)
                    begin
                        for (i = 0; i < used; i++)
                            owe(slots[i], ST_OK, i + 1 == used);
                        return;
                    end
                end
                default: ;
            endcase
            owe('0, st, 1'b1);
        endfunction

        task check_result(input logic signed [VAL_W-1:0] el, input logic [ST_W-1:0] st,
                          input logic [LEN_W-1:0] len, input logic lst);
            list_result_t x;
            if (awaited.size() == 0)
            begin
                report($sformatf("result with none expected: el=%0d st=%0d len=%0d last=%0b",
                                 el, st, len, lst));
                return;
            end
            x = awaited.pop_front();
            if (el !== x.element)
                report($sformatf("element %0d, expected %0d", el, x.element));
            if (st !== x.status)
                report($sformatf("status %0d, expected %0d", st, x.status));
            if (len !== x.length)
                report($sformatf("length %0d, expected %0d", len, x.length));
            if (lst !== x.last)
                report($sformatf("last %0b, expected %0b", lst, x.last));
        endtask
    endclass

    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    start    = 1'b0;
    logic [OP_W-1:0]         opcode   = '0;
    logic signed [VAL_W-1:0] value    = '0;
    logic [POS_W-1:0]        position = '0;
    logic                    busy;
    logic                    result_valid;
    logic signed [VAL_W-1:0] element;
    logic [ST_W-1:0]         status;
    logic [LEN_W-1:0]        length;
    logic                    last;

    list_shadow shadow;
    bit         idle_on;
    bit         filling;

    positional_list_engine #(
        .CAPACITY     (CAP)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .value        (value),
        .position     (position),
        .result_valid (result_valid),
        .element      (element),
        .status       (status),
        .length       (length),
        .last         (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            shadow.check_result(element, status, length, last);
    end

    task automatic drive_item(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                              input logic [POS_W-1:0] pos);
        if (idle_on && $urandom_range(0, 99) < 20)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        value    <= val;
        position <= pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        shadow.note_item(op, val, pos);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (shadow.awaited.size() != 0);
    endtask

    task automatic pick_random(output logic [OP_W-1:0] op, output logic signed [VAL_W-1:0] val,
                               output logic [POS_W-1:0] pos);
        int unsigned r;
        int unsigned cnt;
        cnt = shadow.used;
        if (cnt == CAP)
            filling = 1'b0;
        else if (cnt == 0)
            filling = 1'b1;
        else if ($urandom_range(0, 49) == 0)
            filling = !filling;
        r = $urandom_range(0, 99);
        if (r < 12)
            op = OP_DUMP;
        else if (r < 15)
            op = OP_UNUSED;
        else if (r < (filling ? 75 : 40))
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_INS_FIRST;
                1:       op = OP_INS_LAST;
                default: op = OP_INS_AT;
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_DEL_FIRST;
                1:       op = OP_DEL_LAST;
                default: op = OP_DEL_AT;
            endcase
        end
        case ($urandom_range(0, 9))
            0:       val = VAL_MIN;
            1:       val = VAL_MAX;
            default: val = $urandom;
        endcase
        pos = POS_W'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < 85)
        begin
            if (op == OP_INS_AT)
                pos = POS_W'($urandom_range(1, cnt + 1));
            else if (op == OP_DEL_AT && cnt > 0)
                pos = POS_W'($urandom_range(1, cnt));
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [OP_W-1:0]         op;
        logic signed [VAL_W-1:0] val;
        logic [POS_W-1:0]        pos;
        int                      k;
        int                      guard;

        shadow  = new();
        idle_on = 1'b1;
        filling = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: dump, deletes (empty wins over bad position), bad inserts, unused op
        drive_item(OP_DUMP, '0, '0);
        drive_item(OP_DEL_FIRST, '0, '0);
        drive_item(OP_DEL_AT, '0, 5'd0);
        drive_item(OP_DEL_LAST, '0, '0);
        drive_item(OP_INS_AT, 32'sd5, 5'd0);
        drive_item(OP_INS_AT, 32'sd6, 5'd2);
        drive_item(OP_UNUSED, VAL_MAX, 5'd31);

        // fill to capacity with a mix of inserts and extreme values
        for (k = 0; k < CAP; k++)
        begin
            case (k)
                0:       val = VAL_MIN;
                1:       val = VAL_MAX;
                2:       val = '0;
                3:       val = -32'sd1;
                default: val = $urandom;
            endcase
            if (k % 3 == 0)
                drive_item(OP_INS_FIRST, val, '0);
            else if (k % 3 == 1)
                drive_item(OP_INS_LAST, val, 5'd31);
            else if (k == 2)
                drive_item(OP_INS_AT, val, 5'd1);
            else if (k == 5)
                drive_item(OP_INS_AT, val, POS_W'(shadow.used + 1));
            else
                drive_item(OP_INS_AT, val, POS_W'($urandom_range(1, shadow.used + 1)));
        end

        // full list: full wins over bad position, then a dump and deletes at bad and valid positions
        drive_item(OP_INS_AT, 32'sd7, 5'd0);
        drive_item(OP_INS_LAST, 32'sd8, '0);
        drive_item(OP_DUMP, '0, '0);
        drive_item(OP_DEL_AT, '0, 5'd0);
        drive_item(OP_DEL_AT, '0, 5'd17);
        drive_item(OP_DEL_AT, '0, 5'd16);
        drive_item(OP_DEL_AT, '0, 5'd8);

        wait_drained();

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            idle_on = !(k >= 110 && k < 220);
            if (k == 60 || k == 260)
                wait_drained();
            pick_random(op, val, pos);
            drive_item(op, val, pos);
        end
        start <= 1'b0;

        guard = 0;
        while (shadow.awaited.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (24) @(posedge clk);
        if (shadow.awaited.size() != 0)
            shadow.report($sformatf("%0d results never arrived", shadow.awaited.size()));

        if (shadow.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
